// ----- design/itp_pkg.sv -----
`default_nettype none

package itp_pkg;

  // Default sizes of the operator stack and of the stored precedence.
  localparam int StackDepthDef = 16;
  localparam int PrecBitsDef   = 4;

  // Field widths of the stream payloads.
  localparam int NumW      = 64;
  localparam int CodeW     = 4;
  localparam int PrecW     = 4;
  localparam int TokKindW  = 3;
  localparam int OutKindW  = 2;
  localparam int ErrW      = 2;
  localparam int InDataW   = 72;
  localparam int OutDataW  = 72;

  // Input token kinds.
  localparam logic [TokKindW-1:0] TK_NUM    = 3'd0;
  localparam logic [TokKindW-1:0] TK_OPER   = 3'd1;
  localparam logic [TokKindW-1:0] TK_LPAREN = 3'd2;
  localparam logic [TokKindW-1:0] TK_RPAREN = 3'd3;
  localparam logic [TokKindW-1:0] TK_FUNC   = 3'd4;

  // Result kinds.
  localparam logic [OutKindW-1:0] OK_NUM  = 2'd0;
  localparam logic [OutKindW-1:0] OK_OPER = 2'd1;
  localparam logic [OutKindW-1:0] OK_FUNC = 2'd2;

  // Error codes.
  localparam logic [ErrW-1:0] ERR_NONE      = 2'd0;
  localparam logic [ErrW-1:0] ERR_PAREN     = 2'd1;
  localparam logic [ErrW-1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [ErrW-1:0] ERR_UNDERFLOW = 2'd3;

  // Kind of a stacked entry.
  typedef enum logic [1:0] {
    SK_OPER   = 2'd0,
    SK_LPAREN = 2'd1,
    SK_FUNC   = 2'd2
  } stk_kind_e;

  // Source of a produced result.
  typedef enum logic [1:0] {
    RES_NUM = 2'd0,
    RES_POP = 2'd1,
    RES_ERR = 2'd2
  } res_sel_e;

  // One result item.
  typedef struct packed {
    logic [OutKindW-1:0] kind;
    logic [NumW-1:0]     num;
    logic [CodeW-1:0]    code;
    logic [ErrW-1:0]     err;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_tok;
    logic            push;
    logic            pop;
    logic            clear;
    logic            produce;
    res_sel_e        res_sel;
    logic [ErrW-1:0] err;
    logic            finish;
  } itp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [TokKindW-1:0] tok_kind;
    logic                tok_last;
    logic                sp_zero;
    logic                sp_full;
    stk_kind_e           top_kind;
    logic                top_ge;
    logic                emit_ok;
    logic                pend_valid;
    logic                out_free;
  } itp_stat_t;

endpackage

`default_nettype wire

// ----- design/itp_ctrl.sv -----
`default_nettype none

module itp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire itp_pkg::itp_stat_t stat_i,
  output itp_pkg::itp_cmd_t       cmd_o
);
  import itp_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_OPER     = 6'b000100,
    ST_RPAREN   = 6'b001000,
    ST_RPFUNC   = 6'b010000,
    ST_FLUSH    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  state_e after_step;
  logic   rdy;

  // After a token without error, the end mark leads into the flush.
  assign after_step = stat_i.tok_last ? ST_FLUSH : ST_IDLE;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    rdy     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // The held result of the previous token leaves marked as last.
        rdy          = !stat_i.pend_valid || stat_i.out_free;
        cmd_o.finish = stat_i.pend_valid && stat_i.out_free;
        if (in_valid_i && rdy) begin
          cmd_o.load_tok = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.tok_kind == TK_NUM) begin
          if (stat_i.emit_ok) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_NUM;
            state_d       = after_step;
          end
        end else if (stat_i.tok_kind == TK_OPER) begin
          state_d = ST_OPER;
        end else if (stat_i.tok_kind == TK_LPAREN || stat_i.tok_kind == TK_FUNC) begin
          if (stat_i.sp_full) begin
            if (stat_i.emit_ok) begin
              cmd_o.produce = 1'b1;
              cmd_o.res_sel = RES_ERR;
              cmd_o.err     = ERR_OVERFLOW;
              cmd_o.clear   = 1'b1;
              state_d       = ST_IDLE;
            end
          end else begin
            cmd_o.push = 1'b1;
            state_d    = after_step;
          end
        end else if (stat_i.tok_kind == TK_RPAREN) begin
          if (stat_i.sp_zero) begin
            if (stat_i.emit_ok) begin
              cmd_o.produce = 1'b1;
              cmd_o.res_sel = RES_ERR;
              cmd_o.err     = ERR_UNDERFLOW;
              cmd_o.clear   = 1'b1;
              state_d       = ST_IDLE;
            end
          end else begin
            state_d = ST_RPAREN;
          end
        end else begin
          // Unknown kinds do nothing, but the end mark still flushes.
          state_d = after_step;
        end
      end
      ST_OPER: begin
        // Pop stacked entries that bind at least as tightly, then push.
        if (!stat_i.sp_zero && stat_i.top_kind != SK_LPAREN && stat_i.top_ge) begin
          if (stat_i.emit_ok) begin
            cmd_o.pop     = 1'b1;
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_POP;
          end
        end else if (stat_i.sp_full) begin
          if (stat_i.emit_ok) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_ERR;
            cmd_o.err     = ERR_OVERFLOW;
            cmd_o.clear   = 1'b1;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = after_step;
        end
      end
      ST_RPAREN: begin
        // Pop down to the matching left parenthesis and drop it.
        if (stat_i.sp_zero) begin
          if (stat_i.emit_ok) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_ERR;
            cmd_o.err     = ERR_PAREN;
            cmd_o.clear   = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (stat_i.top_kind != SK_LPAREN) begin
          if (stat_i.emit_ok) begin
            cmd_o.pop     = 1'b1;
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_POP;
          end
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_RPFUNC;
        end
      end
      ST_RPFUNC: begin
        // A function right under the parenthesis is emitted as well.
        if (!stat_i.sp_zero && stat_i.top_kind == SK_FUNC) begin
          if (stat_i.emit_ok) begin
            cmd_o.pop     = 1'b1;
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_POP;
            state_d       = after_step;
          end
        end else begin
          state_d = after_step;
        end
      end
      ST_FLUSH: begin
        if (stat_i.sp_zero) begin
          state_d = ST_IDLE;
        end else if (stat_i.top_kind == SK_LPAREN) begin
          if (stat_i.emit_ok) begin
            cmd_o.produce = 1'b1;
            cmd_o.res_sel = RES_ERR;
            cmd_o.err     = ERR_PAREN;
            cmd_o.clear   = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (stat_i.emit_ok) begin
          cmd_o.pop     = 1'b1;
          cmd_o.produce = 1'b1;
          cmd_o.res_sel = RES_POP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = rdy;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/itp_datapath.sv -----
`default_nettype none

module itp_datapath #(
  parameter int StackDepth = itp_pkg::StackDepthDef,
  parameter int PrecBits   = itp_pkg::PrecBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [itp_pkg::TokKindW-1:0]   tok_kind_i,
  input  wire logic [itp_pkg::NumW-1:0]       tok_num_i,
  input  wire logic [itp_pkg::CodeW-1:0]      tok_code_i,
  input  wire logic [itp_pkg::PrecW-1:0]      tok_prec_i,
  input  wire logic                           tok_last_i,
  input  wire itp_pkg::itp_cmd_t              cmd_i,
  output itp_pkg::itp_stat_t                  stat_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output itp_pkg::res_t                       out_res_o,
  output logic                                out_last_o
);
  import itp_pkg::*;

  // Stored precedence keeps only the low PrecBits of the field.
  localparam int PW   = (PrecBits < PrecW) ? PrecBits : PrecW;
  localparam int EW   = PW + CodeW + 2;
  localparam int SpW  = $clog2(StackDepth + 1);
  localparam int AW   = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  // Token register.
  logic [TokKindW-1:0] tok_kind_q;
  logic [NumW-1:0]     tok_num_q;
  logic [CodeW-1:0]    tok_code_q;
  logic [PW-1:0]       tok_prec_q;
  logic                tok_last_q;

  // Operator stack: memory plus a register that mirrors the top entry.
  logic [EW-1:0]  stack_mem [StackDepth];
  logic [EW-1:0]  top_q;
  logic [EW-1:0]  push_entry;
  logic [SpW-1:0] sp_q, sp_d;
  logic [SpW-1:0] rd_ptr;
  stk_kind_e      push_kind;
  stk_kind_e      top_kind;

  // Held result and output register.
  res_t pend_q, pend_d;
  logic pend_valid_q;
  res_t out_q;
  logic out_valid_q;
  logic out_last_q;
  logic out_free;
  logic move_out;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tok) begin
      tok_kind_q <= tok_kind_i;
      tok_num_q  <= tok_num_i;
      tok_code_q <= tok_code_i;
      tok_prec_q <= tok_prec_i[PW-1:0];
      tok_last_q <= tok_last_i;
    end
  end

  // Entry pushed for the current token.
  always_comb begin
    if (tok_kind_q == TK_OPER) begin
      push_kind = SK_OPER;
    end else if (tok_kind_q == TK_LPAREN) begin
      push_kind = SK_LPAREN;
    end else begin
      push_kind = SK_FUNC;
    end
  end
  assign push_entry = {push_kind, tok_code_q, tok_prec_q};

  // Stack pointer update; an error clears the whole stack.
  always_comb begin
    sp_d = sp_q;
    priority if (cmd_i.clear) begin
      sp_d = '0;
    end else if (cmd_i.push) begin
      sp_d = sp_q + SpW'(1);
    end else if (cmd_i.pop) begin
      sp_d = sp_q - SpW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  // Read the entry under the next pointer; a push goes straight to the top.
  assign rd_ptr = sp_d - SpW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_mem[sp_q[AW-1:0]] <= push_entry;
      top_q                   <= push_entry;
    end else begin
      top_q <= stack_mem[rd_ptr[AW-1:0]];
    end
  end

  assign top_kind = stk_kind_e'(top_q[EW-1:EW-2]);

  // New result for the held slot.
  always_comb begin
    pend_d = '0;
    unique case (cmd_i.res_sel)
      RES_NUM: begin
        pend_d.kind = OK_NUM;
        pend_d.num  = tok_num_q;
      end
      RES_POP: begin
        pend_d.kind = (top_kind == SK_FUNC) ? OK_FUNC : OK_OPER;
        pend_d.code = top_q[PW+CodeW-1:PW];
      end
      RES_ERR: begin
        pend_d.err = cmd_i.err;
      end
      default: begin
        pend_d = '0;
      end
    endcase
  end

  // A result waits in the held slot until it is known whether it ends the run.
  assign out_free = !out_valid_q || out_ready_i;
  assign move_out = (cmd_i.produce && pend_valid_q) || cmd_i.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.produce) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end
      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.produce) begin
      pend_q <= pend_d;
    end
    if (move_out) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.finish;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.tok_kind   = tok_kind_q;
    stat_o.tok_last   = tok_last_q;
    stat_o.sp_zero    = (sp_q == '0);
    stat_o.sp_full    = (sp_q >= SpW'(StackDepth));
    stat_o.top_kind   = top_kind;
    stat_o.top_ge     = (top_q[PW-1:0] >= tok_prec_q);
    stat_o.emit_ok    = !pend_valid_q || out_free;
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- design/infix_to_postfix_converter_top.sv -----
// Channel   Dir  tdata (low bit first)                            tuser        tlast
// s_axis    in   number_bits[63:0] operator_code[67:64]           token_kind   end_of_expression
//                precedence[71:68]
// m_axis    out  out_number_bits[63:0] out_operator_code[67:64]   out_kind     last_of_run
//                error_code[69:68], zero pad[71:70]
//
// A token is taken and then dispatched; an operator then pops entries one at a time before
// its push, and a right parenthesis pops those above its left parenthesis, drops it and
// emits a function right under it. An end mark then flushes the stack entry by entry; an error
// ends the token at once. The stack memory has one read port and a registered top entry.
// Reset empties the stack at once; stack entries are undefined until pushed.
// A stalled output holds steps that produce results and the input while a last result waits.
`default_nettype none

module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH     = itp_pkg::StackDepthDef,
  parameter int PRECEDENCE_BITS = itp_pkg::PrecBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // number_bits, operator_code, precedence
  input  wire logic [itp_pkg::InDataW-1:0]    s_axis_tdata_i,
  // token_kind
  input  wire logic [itp_pkg::TokKindW-1:0]   s_axis_tuser_i,
  input  wire logic                           s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // out_number_bits, out_operator_code, error_code, zero pad
  output logic [itp_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // out_kind
  output logic [itp_pkg::OutKindW-1:0]        m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import itp_pkg::*;

  itp_cmd_t  cmd;
  itp_stat_t stat;
  res_t      out_res;

  // Sequencer for the shunting-yard steps.
  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Token register, operator stack and result registers.
  itp_datapath #(
    .StackDepth (STACK_DEPTH),
    .PrecBits   (PRECEDENCE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_kind_i  (s_axis_tuser_i),
    .tok_num_i   (s_axis_tdata_i[NumW-1:0]),
    .tok_code_i  (s_axis_tdata_i[NumW+CodeW-1:NumW]),
    .tok_prec_i  (s_axis_tdata_i[NumW+CodeW+PrecW-1:NumW+CodeW]),
    .tok_last_i  (s_axis_tlast_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack the result fields.
  assign m_axis_tdata_o = {2'b00, out_res.err, out_res.code, out_res.num};
  assign m_axis_tuser_o = out_res.kind;

endmodule

`default_nettype wire

// ----- design/itp_checker.sv -----
`default_nettype none

module itp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [itp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input wire logic [itp_pkg::OutKindW-1:0]   m_axis_tuser_o,
  input wire logic                           m_axis_tlast_o
);
  import itp_pkg::*;

  logic [ErrW-1:0] err;
  assign err = m_axis_tdata_o[NumW+CodeW+ErrW-1:NumW+CodeW];

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  // An error aborts the token, so it is always the last result of the run.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err != ERR_NONE |-> m_axis_tlast_o)
    else $error("error result not marked last");

  // An error result carries no number and no operator.
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && err != ERR_NONE |->
      m_axis_tuser_o == OK_NUM && m_axis_tdata_o[NumW+CodeW-1:0] == '0)
    else $error("error result has payload");

  // Popped operators and functions carry zero number bits and no error.
  a_pop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != OK_NUM |->
      m_axis_tdata_o[NumW-1:0] == '0 && err == ERR_NONE)
    else $error("operator result has number bits or error");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
module testbench;
  import itp_pkg::*;

  localparam int StackDepth = itp_pkg::StackDepthDef;
  localparam int PrecBits   = itp_pkg::PrecBitsDef;
  localparam logic [PrecW-1:0] PrecMask = PrecW'((1 << PrecBits) - 1);

  // Token kinds above the function kind carry nothing and are dropped by the block.
  localparam logic [TokKindW-1:0] TK_SPARE5 = 3'd5;
  localparam logic [TokKindW-1:0] TK_SPARE7 = 3'd7;

  localparam int RandomItems = 390;
  localparam int LongHold    = 300;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 40;
  localparam int NumRows     = 25;

  // One infix token as it travels on the input stream.
  typedef struct packed {
    logic [TokKindW-1:0] kind;
    logic [NumW-1:0]     num;
    logic [CodeW-1:0]    code;
    logic [PrecW-1:0]    prec;
    logic                last;
  } token_t;

  // One postfix token as it leaves the block.
  typedef struct packed {
    logic [OutKindW-1:0] kind;
    logic [NumW-1:0]     num;
    logic [CodeW-1:0]    code;
    logic                last;
    logic [ErrW-1:0]     err;
  } postfix_t;

  typedef struct packed {
    stk_kind_e        kind;
    logic [CodeW-1:0] code;
    logic [PrecW-1:0] prec;
  } stk_entry_t;

  // A directed row: the token, how often it is sent, and an optional single typed result.
  typedef struct packed {
    logic [TokKindW-1:0] kind;
    logic [NumW-1:0]     num;
    logic [CodeW-1:0]    code;
    logic [PrecW-1:0]    prec;
    logic                last;
    logic [4:0]          reps;
    logic                typed;
    logic [OutKindW-1:0] w_kind;
    logic [NumW-1:0]     w_num;
    logic [ErrW-1:0]     w_err;
  } stim_row_t;

  stim_row_t stim_rows [NumRows] = '{
    // kind     number                  code  prec  last  reps  typed  result kind/number/error
    '{TK_NUM,    64'h0,                  4'd0, 4'd0, 1'b0, 5'd1, 1'b1, OK_NUM, 64'h0, ERR_NONE},
    '{TK_NUM,    64'hffff_ffff_ffff_ffff, 4'd0, 4'd0, 1'b1, 5'd1, 1'b1,
      OK_NUM, 64'hffff_ffff_ffff_ffff, ERR_NONE},
    '{TK_RPAREN, 64'h0,                  4'hf, 4'hf, 1'b0, 5'd1, 1'b1, OK_NUM, 64'h0, ERR_UNDERFLOW},
    '{TK_FUNC,   64'h0,                  4'hf, 4'hf, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_LPAREN, 64'h0,                  4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_NUM,    64'h0123_4567_89ab_cdef, 4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_OPER,   64'h0,                  4'd0, 4'd1, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_NUM,    64'ha5a5_5a5a_0f0f_f0f0, 4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_OPER,   64'h0,                  4'd2, 4'd2, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_NUM,    64'h8000_0000_0000_0001, 4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_OPER,   64'h0,                  4'd1, 4'd1, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_NUM,    64'h7fff_ffff_ffff_fffe, 4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_RPAREN, 64'h0,                  4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_OPER,   64'h0,                  4'd3, 4'hf, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_NUM,    64'h2a,                 4'd0, 4'd0, 1'b1, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_LPAREN, 64'h0,                  4'd6, 4'd9, 1'b1, 5'd1, 1'b1, OK_NUM, 64'h0, ERR_PAREN},
    '{TK_OPER,   64'h0,                  4'hf, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_RPAREN, 64'h0,                  4'd0, 4'd0, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_OPER,   64'h0,                  4'd5, 4'd7, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_SPARE5, 64'h0,                  4'd0, 4'd0, 1'b1, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_SPARE7, 64'hffff_0000_ffff_0000, 4'hf, 4'hf, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_LPAREN, 64'h0,                  4'ha, 4'hc, 1'b0, 5'd16, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_FUNC,   64'h0,                  4'd9, 4'd3, 1'b1, 5'd1, 1'b1, OK_NUM, 64'h0, ERR_OVERFLOW},
    '{TK_FUNC,   64'h0,                  4'd9, 4'd3, 1'b0, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE},
    '{TK_OPER,   64'h0,                  4'd2, 4'd3, 1'b1, 5'd1, 1'b0, OK_NUM, 64'h0, ERR_NONE}
  };

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                tok_valid = 1'b0;
  logic [InDataW-1:0]  tok_data = '0;
  logic [TokKindW-1:0] tok_kind = '0;
  logic                tok_last = 1'b0;
  logic                res_ready = 1'b0;
  logic                tok_ready;
  logic                res_valid;
  logic [OutDataW-1:0] res_data;
  logic [OutKindW-1:0] res_kind;
  logic                res_last;

  // Shunting-yard state of the predictor.
  stk_entry_t  op_stack [StackDepth];
  int unsigned stack_level = 0;

  postfix_t    postfix_q[$];
  token_t      expr_tokens[$];
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 23;
  int unsigned rx_idle_pct = 68;
  int unsigned stall_asked = 0;
  int unsigned stall_done = 0;
  int unsigned quiet_cycles = 0;

  infix_to_postfix_converter_top #(
    .STACK_DEPTH    (StackDepth),
    .PRECEDENCE_BITS(PrecBits)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(tok_valid),
    .s_axis_tready_o(tok_ready),
    .s_axis_tdata_i (tok_data),
    .s_axis_tuser_i (tok_kind),
    .s_axis_tlast_i (tok_last),
    .m_axis_tvalid_o(res_valid),
    .m_axis_tready_i(res_ready),
    .m_axis_tdata_o (res_data),
    .m_axis_tuser_o (res_kind),
    .m_axis_tlast_o (res_last)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic postfix_t make_result(logic [OutKindW-1:0] kind, logic [NumW-1:0] num,
                                           logic [CodeW-1:0] code, logic [ErrW-1:0] err);
    postfix_t r;
    r.kind = kind;
    r.num  = num;
    r.code = code;
    r.last = 1'b0;
    r.err  = err;
    return r;
  endfunction

  // Pops the top entry and emits it as an operator or a function.
  function automatic void pop_operator(ref postfix_t outs[$]);
    stk_entry_t e;
    e = op_stack[stack_level - 1];
    stack_level--;
    outs.push_back(make_result(e.kind == SK_FUNC ? OK_FUNC : OK_OPER, '0, e.code, ERR_NONE));
  endfunction

  // An error emits one error token and throws the whole expression away.
  function automatic void abort_expression(ref postfix_t outs[$], input logic [ErrW-1:0] err);
    outs.push_back(make_result(OK_NUM, '0, '0, err));
    stack_level = 0;
  endfunction

  function automatic bit push_entry(stk_kind_e kind, logic [CodeW-1:0] code,
                                    logic [PrecW-1:0] prec);
    if (stack_level >= StackDepth) return 1'b0;
    op_stack[stack_level] = '{kind, code, prec};
    stack_level++;
    return 1'b1;
  endfunction

  // Postfix tokens caused by one infix token.
  function automatic void convert_token(input token_t t, ref postfix_t outs[$]);
    logic [PrecW-1:0] prec;
    bit               failed;
    prec   = t.prec & PrecMask;
    failed = 1'b0;
    outs.delete();
    case (t.kind)
      TK_NUM: begin
        outs.push_back(make_result(OK_NUM, t.num, '0, ERR_NONE));
      end
      TK_OPER: begin
        while (stack_level > 0 && op_stack[stack_level - 1].kind != SK_LPAREN &&
               op_stack[stack_level - 1].prec >= prec)
          pop_operator(outs);
        if (!push_entry(SK_OPER, t.code, prec)) begin
          abort_expression(outs, ERR_OVERFLOW);
          failed = 1'b1;
        end
      end
      TK_LPAREN, TK_FUNC: begin
        if (!push_entry(t.kind == TK_FUNC ? SK_FUNC : SK_LPAREN, t.code, prec)) begin
          abort_expression(outs, ERR_OVERFLOW);
          failed = 1'b1;
        end
      end
      TK_RPAREN: begin
        if (stack_level == 0) begin
          abort_expression(outs, ERR_UNDERFLOW);
          failed = 1'b1;
        end else begin
          while (stack_level > 0 && op_stack[stack_level - 1].kind != SK_LPAREN)
            pop_operator(outs);
          if (stack_level == 0) begin
            abort_expression(outs, ERR_PAREN);
            failed = 1'b1;
          end else begin
            // Drop the left parenthesis; a function right below it is complete now.
            stack_level--;
            if (stack_level > 0 && op_stack[stack_level - 1].kind == SK_FUNC)
              pop_operator(outs);
          end
        end
      end
      default: begin
      end
    endcase
    // The end mark flushes the stack; an open parenthesis there is an error.
    if (t.last && !failed) begin
      while (stack_level > 0 && !failed) begin
        if (op_stack[stack_level - 1].kind == SK_LPAREN) begin
          abort_expression(outs, ERR_PAREN);
          failed = 1'b1;
        end else begin
          pop_operator(outs);
        end
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
  endfunction

  function automatic token_t rand_token(logic [TokKindW-1:0] kind);
    token_t t;
    t.kind = kind;
    t.num  = {$urandom, $urandom};
    case ($urandom_range(7))
      0: t.num = '0;
      1: t.num = '1;
      default: begin
      end
    endcase
    t.code = CodeW'((kind == TK_OPER && $urandom_range(3) != 0) ?
                    $urandom_range(3) : $urandom_range(15));
    t.prec = PrecW'($urandom_range(15));
    t.last = 1'b0;
    return t;
  endfunction

  // Builds one well-formed expression with random nesting, operators and functions.
  function automatic void build_expression(int unsigned max_nest, int unsigned max_len);
    int unsigned open_parens;
    bit          want_operand;
    bit          done;
    open_parens  = 0;
    want_operand = 1'b1;
    done         = 1'b0;
    while (!done) begin
      if (want_operand) begin
        if (open_parens < max_nest && expr_tokens.size() < max_len &&
            $urandom_range(2) == 0) begin
          if ($urandom_range(1) == 1) expr_tokens.push_back(rand_token(TK_FUNC));
          expr_tokens.push_back(rand_token(TK_LPAREN));
          open_parens++;
        end else begin
          expr_tokens.push_back(rand_token(TK_NUM));
          want_operand = 1'b0;
        end
      end else if (open_parens > 0 &&
                   (expr_tokens.size() >= max_len || $urandom_range(2) == 0)) begin
        expr_tokens.push_back(rand_token(TK_RPAREN));
        open_parens--;
      end else if (expr_tokens.size() < max_len && $urandom_range(3) != 0) begin
        expr_tokens.push_back(rand_token(TK_OPER));
        want_operand = 1'b1;
      end else if (open_parens == 0) begin
        done = 1'b1;
      end
    end
    expr_tokens[expr_tokens.size() - 1].last = 1'b1;
  endfunction

  // Next group of tokens: mostly whole expressions, some broken ones, some noise.
  function automatic void next_batch();
    int unsigned pick;
    token_t      t;
    expr_tokens.delete();
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 4)) begin
        t      = rand_token(TokKindW'($urandom_range(7)));
        t.last = ($urandom_range(2) == 0);
        expr_tokens.push_back(t);
      end
    end else begin
      build_expression(($urandom_range(3) == 0) ? 9 : 3,
                       ($urandom_range(7) == 0) ? 40 : $urandom_range(3, 15));
      if (pick < 22) begin
        expr_tokens.delete($urandom_range(expr_tokens.size() - 1));
        if (expr_tokens.size() > 0) expr_tokens[expr_tokens.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // Offers one token, waits for its transfer, then records what it must produce.
  task automatic send_token(input token_t t, input bit typed, input postfix_t typed_res);
    postfix_t step_out[$];
    if ($urandom_range(99) < tx_idle_pct) begin
      tok_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    tok_valid <= 1'b1;
    tok_data  <= {t.prec, t.code, t.num};
    tok_kind  <= t.kind;
    tok_last  <= t.last;
    @(posedge clk);
    while (!tok_ready) @(posedge clk);
    convert_token(t, step_out);
    if (typed) begin
      postfix_q.push_back(typed_res);
    end else begin
      foreach (step_out[i]) postfix_q.push_back(step_out[i]);
    end
  endtask

  function automatic void check_field(string name, logic [NumW-1:0] want, logic [NumW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (stall_asked != stall_done) begin
        stall_done = stall_asked;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Each result transfer is compared with the oldest expected postfix token.
  always @(posedge clk) begin : result_check
    postfix_t want;
    if (rst_n && res_valid && res_ready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected result: kind %0d data 0x%0h", res_kind, res_data);
        mismatches++;
      end else begin
        want = postfix_q.pop_front();
        check_field("out_kind", NumW'(want.kind), NumW'(res_kind));
        check_field("out_number_bits", want.num, res_data[63:0]);
        check_field("out_operator_code", NumW'(want.code), NumW'(res_data[67:64]));
        check_field("error_code", NumW'(want.err), NumW'(res_data[69:68]));
        check_field("zero pad", '0, NumW'(res_data[71:70]));
        check_field("last_of_run", NumW'(want.last), NumW'(res_last));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (tok_valid && tok_ready) || (res_valid && res_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin : stimulus
    token_t      t;
    postfix_t    want;
    int unsigned fed;
    bit          late_hold;
    fed       = 0;
    late_hold = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed tokens from the table.
    foreach (stim_rows[r]) begin
      t = token_t'({stim_rows[r].kind, stim_rows[r].num, stim_rows[r].code,
                    stim_rows[r].prec, stim_rows[r].last});
      want      = make_result(stim_rows[r].w_kind, stim_rows[r].w_num, '0, stim_rows[r].w_err);
      want.last = 1'b1;
      repeat (stim_rows[r].reps) send_token(t, stim_rows[r].typed, want);
    end

    // Random expressions in three idling phases, with long output hold-offs.
    stall_asked++;
    while (fed < RandomItems) begin
      if (fed < RandomItems / 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 68;
      end else if (fed < 2 * RandomItems / 3) begin
        tx_idle_pct = 68;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!late_hold) begin
          late_hold = 1'b1;
          stall_asked++;
        end
      end
      next_batch();
      foreach (expr_tokens[i]) begin
        send_token(expr_tokens[i], 1'b0, want);
        if (expr_tokens[i].kind <= TK_FUNC) fed++;
      end
    end

    // Drain, then allow for anything still on its way.
    tok_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/itp_pkg.sv
design/itp_ctrl.sv
design/itp_datapath.sv
design/infix_to_postfix_converter_top.sv
design/itp_checker.sv
dv/testbench.sv
